FILE: rtl/core/gil_pkg.sv
// Shared constants, payload types and pipeline word layouts for the grid index linearizer.
// No dependencies; imported by gil_mac, gil_cell and grid_index_linearizer.
package gil_pkg;

    localparam int GIL_DIMS       = 4;
    localparam int GIL_COORD_BITS = 12;
    localparam int GIL_SIZE_BITS  = GIL_COORD_BITS + 1;
    localparam int GIL_IDX_BITS   = 48;
    localparam int GIL_CNT_BITS   = 3;

    typedef logic [GIL_COORD_BITS-1:0] coord_t;
    typedef logic [GIL_SIZE_BITS-1:0]  extent_t;
    typedef logic [GIL_IDX_BITS-1:0]   idx_t;
    typedef logic [GIL_CNT_BITS-1:0]   dim_cnt_t;

    localparam extent_t GIL_SIZE_TOP = GIL_SIZE_BITS'(1) << GIL_COORD_BITS;

    typedef enum logic
    {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    // Horner stage word
    typedef struct packed
    {
        logic                    valid;
        op_t                     op;
        logic                    flag;
        idx_t                    acc;
        coord_t [GIL_DIMS-1:0]   coord;
    } mac_word_t;

    // divide chain word: one index bit consumed per cell
    typedef struct packed
    {
        logic                    valid;
        op_t                     op;
        logic                    flag;
        idx_t                    idx;
        coord_t [GIL_DIMS-1:1]   rem;
        coord_t                  q0;
        logic                    q0_ovf;
    } cell_word_t;

endpackage

FILE: rtl/core/grid_index_linearizer.sv
// Top level of the grid index linearizer: config registers, entry stage, Horner stages,
// divide cell chain and result register. Depends on gil_pkg, gil_mac and gil_cell.
//
// Usage:
//   Items: drive operation, coord_in_*, index_in with start; a word is taken at each
//   clock edge with start high and busy low. busy is high only in a cycle where a
//   config write is taken, so items can be issued every cycle.
//   Results: done pulses for one cycle with index_out, coord_out_*, out_of_range.
//   The receiver cannot stall; results leave in issue order, one per cycle at most.
//   Pipeline: entry stage, three Horner multiply stages, 48 divide cells, one per
//   index bit, and the result register. Throughput: one word per cycle while busy
//   is low; the divide chain retires one index bit per cell.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is high only
//   while no word is in flight. Index 0 is the dimension count, 1 to 4 the sizes;
//   higher indexes are ignored.
//   Reset: dimension count 4, all sizes 4096, pipeline emptied, done low.
module grid_index_linearizer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             operation,
    input  gil_pkg::coord_t  coord_in_0,
    input  gil_pkg::coord_t  coord_in_1,
    input  gil_pkg::coord_t  coord_in_2,
    input  gil_pkg::coord_t  coord_in_3,
    input  gil_pkg::idx_t    index_in,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  gil_pkg::extent_t cfg_data,
    output logic             done,
    output gil_pkg::idx_t    index_out,
    output gil_pkg::coord_t  coord_out_0,
    output gil_pkg::coord_t  coord_out_1,
    output gil_pkg::coord_t  coord_out_2,
    output gil_pkg::coord_t  coord_out_3,
    output logic             out_of_range
);
    import gil_pkg::*;

    typedef enum logic [2:0]
    {
        CFG_DIM_COUNT = 3'd0,
        CFG_SIZE_0    = 3'd1,
        CFG_SIZE_1    = 3'd2,
        CFG_SIZE_2    = 3'd3,
        CFG_SIZE_3    = 3'd4
    } cfg_reg_t;

    dim_cnt_t                dim_count_reg;
    extent_t [GIL_DIMS-1:0]  size_reg;
    dim_cnt_t                dims_eff;
    extent_t [GIL_DIMS-1:0]  ext;
    coord_t  [GIL_DIMS-1:0]  cin;

    mac_word_t               s0_reg;
    mac_word_t               s0_next;
    mac_word_t               mac_w [GIL_DIMS];
    cell_word_t              cell_w [GIL_IDX_BITS+1];
    cell_word_t              last;

    logic                    done_reg;
    idx_t                    index_out_reg;
    idx_t                    index_out_next;
    coord_t  [GIL_DIMS-1:0]  coord_out_reg;
    coord_t  [GIL_DIMS-1:0]  coord_out_next;
    logic                    oor_reg;
    logic                    oor_next;
    logic                    pipe_active;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_count_reg <= GIL_CNT_BITS'(GIL_DIMS);
            size_reg      <= {GIL_DIMS{GIL_SIZE_TOP}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_DIM_COUNT: dim_count_reg <= cfg_data[GIL_CNT_BITS-1:0];
                CFG_SIZE_0:    size_reg[0]   <= cfg_data;
                CFG_SIZE_1:    size_reg[1]   <= cfg_data;
                CFG_SIZE_2:    size_reg[2]   <= cfg_data;
                CFG_SIZE_3:    size_reg[3]   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // effective sizes; dims not in use act as size one
    always_comb
    begin
        dims_eff = dim_count_reg;
        if (dim_count_reg == '0)
        begin
            dims_eff = GIL_CNT_BITS'(1);
        end
        else if (dim_count_reg > GIL_CNT_BITS'(GIL_DIMS))
        begin
            dims_eff = GIL_CNT_BITS'(GIL_DIMS);
        end
        for (int d = 0; d < GIL_DIMS; d++)
        begin
            ext[d] = size_reg[d];
            if (size_reg[d] == '0)
            begin
                ext[d] = GIL_SIZE_BITS'(1);
            end
            else if (size_reg[d] > GIL_SIZE_TOP)
            begin
                ext[d] = GIL_SIZE_TOP;
            end
            if (GIL_CNT_BITS'(d) >= dims_eff)
            begin
                ext[d] = GIL_SIZE_BITS'(1);
            end
        end
    end

    assign cin = {coord_in_3, coord_in_2, coord_in_1, coord_in_0};

    // entry stage
    always_comb
    begin
        s0_next       = '0;
        s0_next.valid = start & ~busy;
        s0_next.op    = op_t'(operation);
        for (int d = 0; d < GIL_DIMS; d++)
        begin
            if (GIL_CNT_BITS'(d) < dims_eff)
            begin
                s0_next.coord[d] = cin[d];
            end
            if ({1'b0, s0_next.coord[d]} >= ext[d])
            begin
                s0_next.flag = 1'b1;
            end
        end
        if (s0_next.op == OP_ENCODE)
        begin
            s0_next.acc = GIL_IDX_BITS'(s0_next.coord[0]);
        end
        else
        begin
            s0_next.acc = index_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
        end
    end

    assign mac_w[0] = s0_reg;

    for (genvar k = 1; k < GIL_DIMS; k++)
    begin : g_mac
        gil_mac u_mac
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .extent   (ext[k]),
            .coord    (mac_w[k-1].coord[k]),
            .word_in  (mac_w[k-1]),
            .word_out (mac_w[k])
        );
    end

    always_comb
    begin
        cell_w[0]       = '0;
        cell_w[0].valid = mac_w[GIL_DIMS-1].valid;
        cell_w[0].op    = mac_w[GIL_DIMS-1].op;
        cell_w[0].flag  = mac_w[GIL_DIMS-1].flag;
        cell_w[0].idx   = mac_w[GIL_DIMS-1].acc;
    end

    for (genvar j = 0; j < GIL_IDX_BITS; j++)
    begin : g_cell
        gil_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .extent   (ext[GIL_DIMS-1:1]),
            .word_in  (cell_w[j]),
            .word_out (cell_w[j+1])
        );
    end

    assign last = cell_w[GIL_IDX_BITS];

    // result
    always_comb
    begin
        index_out_next = '0;
        coord_out_next = '0;
        if (last.op == OP_ENCODE)
        begin
            index_out_next = last.idx;
            oor_next       = last.flag;
        end
        else
        begin
            coord_out_next[0] = last.q0;
            for (int d = 1; d < GIL_DIMS; d++)
            begin
                coord_out_next[d] = last.rem[d];
            end
            oor_next = last.q0_ovf | ({1'b0, last.q0} >= ext[0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        index_out_reg <= index_out_next;
        coord_out_reg <= coord_out_next;
        oor_reg       <= oor_next;
    end

    always_comb
    begin
        pipe_active = s0_reg.valid | done_reg;
        for (int k = 1; k < GIL_DIMS; k++)
        begin
            pipe_active = pipe_active | mac_w[k].valid;
        end
        for (int j = 1; j <= GIL_IDX_BITS; j++)
        begin
            pipe_active = pipe_active | cell_w[j].valid;
        end
    end

    assign cfg_ready    = ~pipe_active;
    assign busy         = cfg_valid & cfg_ready;
    assign done         = done_reg;
    assign index_out    = index_out_reg;
    assign coord_out_0  = coord_out_reg[0];
    assign coord_out_1  = coord_out_reg[1];
    assign coord_out_2  = coord_out_reg[2];
    assign coord_out_3  = coord_out_reg[3];
    assign out_of_range = oor_reg;

endmodule

FILE: rtl/core/gil_mac.sv
// One Horner step of the encode path: acc = acc * extent + coord for encode words.
// Decode words pass unchanged. Depends on gil_pkg.
module gil_mac
(
    input  logic              clk,
    input  logic              rst_n,
    input  gil_pkg::extent_t  extent,
    input  gil_pkg::coord_t   coord,
    input  gil_pkg::mac_word_t word_in,
    output gil_pkg::mac_word_t word_out
);
    import gil_pkg::*;

    mac_word_t                          out_reg;
    mac_word_t                          out_next;
    logic [GIL_IDX_BITS+GIL_SIZE_BITS-1:0] prod;

    always_comb
    begin
        prod     = word_in.acc * extent;
        out_next = word_in;
        if (word_in.op == OP_ENCODE)
        begin
            out_next.acc = prod[GIL_IDX_BITS-1:0] + GIL_IDX_BITS'(coord);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    assign word_out = out_reg;

endmodule

FILE: rtl/core/gil_cell.sv
// One cell of the decode chain: takes the index MSB and runs it through the cascade of
// restoring-division remainders (dims high to one), shifting the final quotient bit into q0.
// Depends on gil_pkg.
module gil_cell
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  gil_pkg::extent_t [gil_pkg::GIL_DIMS-1:1]     extent,
    input  gil_pkg::cell_word_t                          word_in,
    output gil_pkg::cell_word_t                          word_out
);
    import gil_pkg::*;

    cell_word_t out_reg;
    cell_word_t out_next;

    always_comb
    begin
        logic    b;
        extent_t trial;
        out_next = word_in;
        b        = word_in.idx[GIL_IDX_BITS-1];
        // rotate so the word returns to its entry value after the full chain
        out_next.idx = {word_in.idx[GIL_IDX_BITS-2:0], word_in.idx[GIL_IDX_BITS-1]};
        for (int d = GIL_DIMS - 1; d >= 1; d--)
        begin
            trial = {word_in.rem[d], b};
            if (trial >= extent[d])
            begin
                trial = trial - extent[d];
                b     = 1'b1;
            end
            else
            begin
                b = 1'b0;
            end
            out_next.rem[d] = trial[GIL_COORD_BITS-1:0];
        end
        out_next.q0_ovf = word_in.q0_ovf | word_in.q0[GIL_COORD_BITS-1];
        out_next.q0     = {word_in.q0[GIL_COORD_BITS-2:0], b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    assign word_out = out_reg;

endmodule
